### hw/rtl/deque_with_value_search_top_macros.svh
// ---------------------------------------------------------------------------
// Deque with value search: assertion macros
// Implication checks on the clock and reset of the including module.
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_VALUE_SEARCH_TOP_MACROS_SVH
`define DEQUE_WITH_VALUE_SEARCH_TOP_MACROS_SVH
`ifndef SYNTH
`define DQVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dqvs check failed");
`define DQVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dqvs check failed");
`else
`define DQVS_ASSERT_IMP(lbl, ante, cons)
`define DQVS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/dqvs_pkg.sv
// ---------------------------------------------------------------------------
// Deque with value search: shared package
// Opcodes, status codes, controller states and the per-cell command.
// ---------------------------------------------------------------------------
package dqvs_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_t;

  // Command broadcast to every cell for one beat.
  typedef struct packed {
    logic shift_right;  // push at front: each cell takes its left neighbour
    logic shift_left;   // pop at front: each cell takes its right neighbour
    logic load_back;    // push at back: the cell at the fill count loads
    logic find;         // compare against the key
  } cell_cmd_t;

endpackage

### hw/rtl/dqvs_cell.sv
// ---------------------------------------------------------------------------
// Deque with value search: storage cell
// Holds one entry, shifts with its neighbours and compares against the key.
// ---------------------------------------------------------------------------
module dqvs_cell
  import dqvs_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  cell_cmd_t         cmd,
  input  logic [ValueW-1:0] key,
  input  logic [CW-1:0]     count,
  input  logic [ValueW-1:0] left_data,
  input  logic [ValueW-1:0] right_data,
  output logic [ValueW-1:0] data,
  output logic              match
);

  logic [ValueW-1:0] data_r, data_nxt;
  logic              match_r, match_nxt;
  logic              here;

  assign here = (CW'(IDX) == count);

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    if (en) begin
      if (cmd.shift_right) begin
        data_nxt = left_data;
      end else if (cmd.shift_left) begin
        data_nxt = right_data;
      end else if (cmd.load_back && here) begin
        data_nxt = key;
      end
      // Only occupied positions may report a match.
      match_nxt = cmd.find && (CW'(IDX) < count) && (data_r == key);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

### hw/rtl/dqvs_first_hit.sv
// ---------------------------------------------------------------------------
// Deque with value search: first-hit encoder
// Gives the lowest position whose match bit is set, zero when none is.
// ---------------------------------------------------------------------------
module dqvs_first_hit #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PW    = 4
) (
  input  logic [DEPTH-1:0] match,
  output logic             hit,
  output logic [PW-1:0]    pos
);

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = 1'b1;
        pos = PW'(i);
      end
    end
  end

endmodule

### hw/rtl/deque_with_value_search_top.sv
// ---------------------------------------------------------------------------
// Deque with value search: top level
// Bounded double-ended queue of signed 32-bit values held in a row of cells.
// ---------------------------------------------------------------------------
// Usage. Each input beat carries an opcode on in_tuser and a value on
// in_tdata: push at front, push at back, pop front, pop back, find, clear.
// Every input beat yields exactly one result beat on out_tdata with the
// status, the entry count after the access, and for a find the hit flag and
// the position of the first equal entry counted from the front.
// The entries live in a row of DEPTH cells ordered front to back, so a push
// or pop at the front moves every cell one place along at once and a find
// compares all cells side by side.
// From the accepting edge, the cells update and register their match bits;
// the first-hit encoder across the row then fills the output register.
// No new beat is taken while one is in evaluation, as the row's match bits
// and the output register hold only one result at a time.
// A push on a full store and a pop on an empty store leave the store as it
// is and are flagged in the status. Unused opcodes leave the store as it is.
// Reset empties the store; entry contents are not cleared. When the receiver
// stalls, the result holds in the output register and no new beat is taken
// until it has gone.
// ---------------------------------------------------------------------------
`include "deque_with_value_search_top_macros.svh"

module deque_with_value_search_top
  import dqvs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [6:2] entry_count, [7] hit,
                                  // [11:8] hit_position, [15:12] zero
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_data_r, out_data_nxt;
  logic              accept;
  op_t               op;
  cell_cmd_t         cmd;
  logic [DEPTH-1:0]  match;
  logic              hit;
  logic [PW-1:0]     pos;
  logic [ValueW-1:0] cell_data [DEPTH];
  logic [31:0]       count_wide;
  logic [31:0]       pos_wide;

  assign op        = op_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Decode the beat into the command seen by every cell, the new count and
  // the status to report.
  always_comb begin
    cmd        = '0;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = ST_DONE;
      case (op)
        OP_PUSH_FRONT: begin
          if (count_r == DepthC) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            cmd.shift_right = 1'b1;
            count_nxt       = count_r + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (count_r == DepthC) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            cmd.load_back = 1'b1;
            count_nxt     = count_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (count_r == '0) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            cmd.shift_left = 1'b1;
            count_nxt      = count_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (count_r == '0) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        OP_FIND: begin
          cmd.find = 1'b1;
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Row of cells, front at index zero. The front cell shifts in the key on
  // a push at the front; the back cell keeps its own data on a pop.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ValueW-1:0] left_d, right_d;
    if (g == 0) begin : g_front
      assign left_d = in_tdata;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_back
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    dqvs_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (accept),
      .cmd        (cmd),
      .key        (in_tdata),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .match      (match[g])
    );
  end

  dqvs_first_hit #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_first_hit (
    .match (match),
    .hit   (hit),
    .pos   (pos)
  );

  // Fields are reported modulo their widths.
  assign count_wide = 32'(count_r);
  assign pos_wide   = 32'(pos);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {4'b0000, pos_wide[3:0], hit, count_wide[4:0], status_r};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted beat always moves on to evaluation.
  `DQVS_ASSERT_NXT(a_accept_eval, accept, state_r == S_EVAL)
  // Evaluation always leaves a result waiting.
  `DQVS_ASSERT_NXT(a_eval_result, state_r == S_EVAL, out_valid_r)
  // The fill count never passes the number of cells.
  `DQVS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DepthC)
  // A hit always lies among the stored entries.
  `DQVS_ASSERT_IMP(a_hit_inside, hit, CW'(pos) < count_r)

endmodule

### tb/sv/deque_with_value_search_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Deque with value search: self-checking testbench
// Drives opcode and value beats into the top level, mirrors the store in a
// scoreboard and compares each result beat field by field with the outcome
// predicted from the mirror. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module deque_with_value_search_top_tb;
  import dqvs_pkg::*;

  localparam int unsigned DequeDepth = 16;
  localparam int unsigned AccessTarget = 1200;
  localparam int unsigned PausePeriod = 300;

  // Opcodes the block does not define; they must leave the store untouched.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // One predicted result beat, unpacked into its fields.
  typedef struct {
    status_t    status;
    logic [4:0] count;
    logic       hit;
    logic [3:0] pos;
  } outcome_t;

  // The scoreboard keeps a mirror of the store, front entry at index 0, and
  // a queue of outcomes still owed by the block, oldest first.
  class deque_scoreboard;
    logic [31:0] mirror_entries[$];
    outcome_t    awaited_outcomes[$];
    int unsigned mismatches;

    function void note_access(logic [2:0] op, logic [31:0] val);
      outcome_t o;
      o.status = ST_DONE;
      o.hit    = 1'b0;
      o.pos    = 4'd0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (mirror_entries.size() >= DequeDepth) begin
            o.status = ST_PUSH_FULL;
          end else if (op == OP_PUSH_FRONT) begin
            mirror_entries.push_front(val);
          end else begin
            mirror_entries.push_back(val);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (mirror_entries.size() == 0) begin
            o.status = ST_POP_EMPTY;
          end else if (op == OP_POP_FRONT) begin
            void'(mirror_entries.pop_front());
          end else begin
            void'(mirror_entries.pop_back());
          end
        end
        OP_FIND: begin
          // Only the first equal entry from the front counts.
          foreach (mirror_entries[i]) begin
            if (!o.hit && mirror_entries[i] == val) begin
              o.hit = 1'b1;
              o.pos = 4'(i);
            end
          end
        end
        OP_CLEAR: begin
          mirror_entries.delete();
        end
        default: begin
        end
      endcase
      o.count = 5'(mirror_entries.size());
      awaited_outcomes.push_back(o);
    endfunction

    function void check_result(logic [15:0] beat);
      outcome_t o;
      if (awaited_outcomes.size() == 0) begin
        $error("result beat %h arrived with no access outstanding", beat);
        mismatches++;
        return;
      end
      o = awaited_outcomes.pop_front();
      if (beat[1:0] !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, beat[1:0]);
        mismatches++;
      end
      if (beat[6:2] !== o.count) begin
        $error("entry_count: expected %0d, got %0d", o.count, beat[6:2]);
        mismatches++;
      end
      if (beat[7] !== o.hit) begin
        $error("hit: expected %0d, got %0d", o.hit, beat[7]);
        mismatches++;
      end
      if (beat[11:8] !== o.pos) begin
        $error("hit_position: expected %0d, got %0d", o.pos, beat[11:8]);
        mismatches++;
      end
      if (beat[15:12] !== 4'd0) begin
        $error("padding: expected 0, got %0d", beat[15:12]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] item_value
  logic [2:0]  in_tuser = '0;   // [2:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [1:0] status, [6:2] entry_count, [7] hit,
                                // [11:8] hit_position, [15:12] zero

  deque_scoreboard sb = new();

  // Burst flags switch off the random idling of either side for a stretch.
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned access_count = 0;

  // A small pool of values makes duplicates common, so that a find has to
  // pick the first of several equal entries.
  logic [31:0] value_pool[4] = '{32'h0000_0005, 32'hDEAD_BEEF, 32'h8000_0000,
                                 32'h0000_0000};

  deque_with_value_search_top #(
    .DEPTH(DequeDepth)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: every accepted beat is checked, then a fresh stall is drawn
  // at random, unless a burst is on, before the next beat may be taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tready) begin
        if (out_tvalid) begin
          sb.check_result(out_tdata);
          rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
          if (rx_wait != 0) begin
            out_tready <= 1'b0;
          end
        end
      end else begin
        if (rx_wait > 0) begin
          rx_wait--;
        end
        if (rx_wait == 0) begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Offers one beat after a random gap and returns at the edge on which it
  // is accepted; the scoreboard learns of the access at that same edge.
  task automatic send_access(input logic [2:0] op, input logic [31:0] val);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    sb.note_access(op, val);
    // Spare opcodes are ignored by the block and do not count as work.
    if (op <= OP_CLEAR) begin
      access_count++;
    end
  endtask

  // Holds the sender back until every outstanding result has been seen.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.awaited_outcomes.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5, 6:    v = value_pool[$urandom_range(0, 3)];
      7: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      default: begin
        if (sb.mirror_entries.size() != 0) begin
          v = sb.mirror_entries[$urandom_range(0, sb.mirror_entries.size() - 1)];
        end else begin
          v = $urandom();
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic [2:0] random_push();
    return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  function automatic logic [2:0] random_pop();
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  // Pushes from either end until the store is full, then a few more that
  // must be rejected.
  task automatic fill_store(input int unsigned extra);
    while (sb.mirror_entries.size() < DequeDepth) begin
      send_access(random_push(), pick_value());
    end
    repeat (extra) send_access(random_push(), pick_value());
  endtask

  // Pops from either end until the store is empty, then a few more that
  // must be flagged as ignored.
  task automatic drain_store(input int unsigned extra);
    while (sb.mirror_entries.size() != 0) begin
      send_access(random_pop(), pick_value());
    end
    repeat (extra) send_access(random_pop(), pick_value());
  endtask

  task automatic mixed_accesses(input int unsigned count);
    int unsigned roll;
    logic [2:0]  op;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 22)       op = OP_PUSH_FRONT;
      else if (roll < 44)  op = OP_PUSH_BACK;
      else if (roll < 57)  op = OP_POP_FRONT;
      else if (roll < 70)  op = OP_POP_BACK;
      else if (roll < 95)  op = OP_FIND;
      else if (roll < 97)  op = OP_CLEAR;
      else                 op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      send_access(op, pick_value());
    end
  endtask

  initial begin
    int unsigned next_pause;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: everything on an empty store first, then a small store
    // holding the value extremes, searched for a hit and a miss.
    send_access(OP_POP_FRONT, 32'h0);
    send_access(OP_POP_BACK, 32'hFFFF_FFFF);
    send_access(OP_FIND, 32'h0);
    send_access(OP_CLEAR, 32'h0);
    send_access(OP_SPARE_6, 32'h1234_5678);
    send_access(OP_SPARE_7, 32'h8765_4321);
    send_access(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_access(OP_PUSH_BACK, 32'h8000_0000);
    send_access(OP_PUSH_FRONT, 32'h0000_0000);
    send_access(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_access(OP_FIND, 32'h8000_0000);
    send_access(OP_FIND, 32'h0000_0005);
    send_access(OP_FIND, 32'hFFFF_FFFF);
    send_access(OP_SPARE_6, 32'h0);
    send_access(OP_POP_FRONT, 32'h0);
    send_access(OP_POP_BACK, 32'h0);
    send_access(OP_FIND, 32'h0000_0000);
    send_access(OP_CLEAR, 32'hFFFF_FFFF);
    send_access(OP_FIND, 32'h7FFF_FFFF);
    wait_for_drain();

    // Random part, built from fill, drain, search and mixed sequences.
    next_pause = PausePeriod;
    while (access_count < AccessTarget) begin
      case ($urandom_range(0, 9))
        0, 1: fill_store($urandom_range(0, 3));
        2:    drain_store($urandom_range(0, 3));
        3:    repeat (10) send_access(OP_FIND, pick_value());
        default: mixed_accesses($urandom_range(5, 30));
      endcase
      if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
      if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
      if (access_count >= next_pause) begin
        wait_for_drain();
        next_pause += PausePeriod;
      end
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run, even under the longest
  // idles and stalls.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/dqvs_pkg.sv
hw/rtl/dqvs_cell.sv
hw/rtl/dqvs_first_hit.sv
hw/rtl/deque_with_value_search_top.sv
tb/sv/deque_with_value_search_top_tb.sv
